### hw/rtl/closest_approach_danger_check_core_macros.svh
// Assertion macros for the closest approach danger check core.
`ifndef CLOSEST_APPROACH_DANGER_CHECK_CORE_MACROS_SVH
`define CLOSEST_APPROACH_DANGER_CHECK_CORE_MACROS_SVH

// same-cycle implication, quiet while in reset
`define CADC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, quiet while in reset
`define CADC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/cadc_pkg.sv
// Shared widths, types, the phase conversion and the square root step function for the closest approach danger check.
package cadc_pkg;

	localparam int ANGLE_BITS  = 16;
	localparam int COORD_BITS  = 24;

	localparam int COURSE_BITS = 16;
	localparam int SPEED_BITS  = 16;
	localparam int TRIG_BITS   = 16;
	localparam int DIST_BITS   = 24;
	localparam int DTIME_BITS  = 31;
	localparam int TIME_BITS   = 32;
	localparam int CFG_DATA_BITS = 32;
	localparam int CFG_IDX_BITS  = 2;

	// angle to 16-bit phase
	localparam int ANG_W   = (ANGLE_BITS < COURSE_BITS) ? ANGLE_BITS : COURSE_BITS;
	localparam int ANG_SHR = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
	localparam int ANG_SHL = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;

	// datapath widths
	localparam int PROD33_BITS = SPEED_BITS + TRIG_BITS + 1;
	localparam int VEL_BITS  = PROD33_BITS - 15;
	localparam int PROD_BITS = COORD_BITS + VEL_BITS;
	localparam int DOT_BITS  = PROD_BITS + 1;
	localparam int VSQ_BITS  = 2 * VEL_BITS;
	localparam int VV_BITS   = VSQ_BITS;
	localparam int CSQ_BITS  = 2 * COORD_BITS;
	localparam int CRM_BITS  = PROD_BITS;
	localparam int CRM_LO    = CRM_BITS / 2;
	localparam int CRM_HI    = CRM_BITS - CRM_LO;
	localparam int HH_BITS   = 2 * CRM_HI;
	localparam int HL_BITS   = CRM_HI + CRM_LO;
	localparam int LL_BITS   = 2 * CRM_LO;
	localparam int TIME_SHIFT = 12;
	localparam int NT_BITS   = DOT_BITS + TIME_SHIFT;
	localparam int TQ_BITS   = TIME_BITS - 1;
	localparam int DQ_BITS   = 2 * DIST_BITS;
	localparam int SQ_W      = DQ_BITS + 1;
	localparam int DW_A      = 2 * CRM_BITS;
	localparam int DW_B      = VV_BITS + DQ_BITS;
	localparam int DW        = ((DW_A > DW_B) ? DW_A : DW_B) + 1;
	localparam int TW_B      = VV_BITS + TQ_BITS;
	localparam int TW        = ((NT_BITS > TW_B) ? NT_BITS : TW_B) + 1;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_OWN_COURSE,
		CFG_OWN_SPEED,
		CFG_DANGER_DISTANCE,
		CFG_DANGER_TIME
	} cfg_reg_t;

	// divide operands leaving the geometry front end
	typedef struct packed {
		logic               still;
		logic               tneg;
		logic [NT_BITS-1:0] nt;
		logic [VV_BITS-1:0] dv;
		logic [DW-1:0]      dd;
	} cadc_op_t;

	// time result pieces and flags riding down the pipe
	typedef struct packed {
		logic               still;
		logic               tneg;
		logic               tovf;
		logic               dovf;
		logic [TQ_BITS-1:0] tq;
	} cadc_side_t;

	typedef struct packed {
		cadc_side_t         side;
		logic [DQ_BITS-1:0] dq;
	} cadc_quo_t;

	typedef struct packed {
		logic [SQ_W-1:0]      rem;
		logic [DIST_BITS-1:0] root;
	} cadc_root_t;

	function automatic logic [15:0] phase16(input logic [COURSE_BITS-1:0] a);
		logic [15:0] m;
		m = 16'(a & COURSE_BITS'((33'd1 << ANG_W) - 33'd1));
		return 16'((m >> ANG_SHR) << ANG_SHL);
	endfunction

	// one restoring square root digit: try setting bit k of the root
	function automatic cadc_root_t root_step(input cadc_root_t a, input int unsigned k);
		logic [SQ_W-1:0] trial;
		cadc_root_t r;
		trial = (SQ_W'(a.root) << (k + 1)) + (SQ_W'(1) << (2 * k));
		r = a;
		if (a.rem >= trial) begin
			r.rem  = a.rem - trial;
			r.root = a.root | (DIST_BITS'(1) << k);
		end
		return r;
	endfunction

endpackage

### hw/rtl/closest_approach_danger_check_core.sv
// Top level of the closest approach danger check: config, pipeline and result register.
// One target report enters per cycle while the input is not stalled, and passes through 10
// stages of trig and products, a 49-stage divider (one quotient bit per stage, set by the
// 48-bit squared-distance quotient) and a 24-stage square root, then the result register. A
// stall on the result side freezes the whole pipeline, bubbles included, and stalls the input.
// Configuration writes are taken every cycle (cfg_ready is tied high).
`include "closest_approach_danger_check_core_macros.svh"

module closest_approach_danger_check_core import cadc_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [CFG_DATA_BITS-1:0]     cfg_data,
	input  logic                         target_valid,
	output logic                         target_stall,
	input  logic signed [COORD_BITS-1:0] rel_x,
	input  logic signed [COORD_BITS-1:0] rel_y,
	input  logic [COURSE_BITS-1:0]       target_course,
	input  logic [SPEED_BITS-1:0]        target_speed,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic signed [TIME_BITS-1:0]  time_to_closest,
	output logic [DIST_BITS-1:0]         closest_distance,
	output logic                         is_danger,
	output logic                         no_relative_motion
);

	logic [COURSE_BITS-1:0] own_course_q;
	logic [SPEED_BITS-1:0]  own_speed_q;
	logic [DIST_BITS-1:0]   danger_distance_q;
	logic [DTIME_BITS-1:0]  danger_time_q;

	logic       en;
	logic       geo_vld, div_vld, sq_vld;
	cadc_op_t   geo_op;
	cadc_quo_t  div_quo;
	cadc_side_t sq_side;
	logic [DIST_BITS-1:0] sq_root;

	logic signed [TIME_BITS-1:0] tval;
	logic [DIST_BITS-1:0]        dval;
	logic                        danger;

	logic                        result_valid_q;
	logic signed [TIME_BITS-1:0] time_q;
	logic [DIST_BITS-1:0]        dist_q;
	logic                        danger_q, still_q;

	assign cfg_ready    = 1'b1;
	assign en           = !(result_valid_q && result_stall);
	assign target_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_course_q      <= '0;
			own_speed_q       <= '0;
			danger_distance_q <= '0;
			danger_time_q     <= '0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				CFG_OWN_COURSE: begin
					own_course_q <= cfg_data[COURSE_BITS-1:0];
				end
				CFG_OWN_SPEED: begin
					own_speed_q <= cfg_data[SPEED_BITS-1:0];
				end
				CFG_DANGER_DISTANCE: begin
					danger_distance_q <= cfg_data[DIST_BITS-1:0];
				end
				CFG_DANGER_TIME: begin
					danger_time_q <= cfg_data[DTIME_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	cadc_geom u_geom (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_vld        (target_valid),
		.rel_x         (rel_x),
		.rel_y         (rel_y),
		.target_course (target_course),
		.target_speed  (target_speed),
		.own_course    (own_course_q),
		.own_speed     (own_speed_q),
		.out_vld       (geo_vld),
		.op            (geo_op)
	);

	cadc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (geo_vld),
		.op      (geo_op),
		.out_vld (div_vld),
		.quo     (div_quo)
	);

	cadc_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (div_vld),
		.quo     (div_quo),
		.out_vld (sq_vld),
		.side    (sq_side),
		.root    (sq_root)
	);

	// truncate toward zero, saturate to 32 bits
	always_comb begin
		if (sq_side.still) begin
			tval = '0;
		end else if (sq_side.tovf) begin
			tval = sq_side.tneg ? {1'b1, {(TIME_BITS-1){1'b0}}} : {1'b0, {(TIME_BITS-1){1'b1}}};
		end else if (sq_side.tneg) begin
			tval = -signed'({1'b0, sq_side.tq});
		end else begin
			tval = signed'({1'b0, sq_side.tq});
		end
		dval   = sq_side.dovf ? '1 : sq_root;
		danger = !tval[TIME_BITS-1] && (tval != '0) &&
		         (tval[TIME_BITS-2:0] < danger_time_q) &&
		         (dval != '0) && (dval < danger_distance_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (en) begin
			result_valid_q <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			time_q   <= tval;
			dist_q   <= dval;
			danger_q <= danger;
			still_q  <= sq_side.still;
		end
	end

	assign result_valid       = result_valid_q;
	assign time_to_closest    = time_q;
	assign closest_distance   = dist_q;
	assign is_danger          = danger_q;
	assign no_relative_motion = still_q;

	`CADC_ASSERT_NOW(a_stall_needs_result, target_stall, result_valid_q, "input stalled with no result held")
	`CADC_ASSERT_NOW(a_still_is_quiet, result_valid_q && no_relative_motion, time_q == '0 && !danger_q, "no relative motion with nonzero time or danger")
	`CADC_ASSERT_NOW(a_danger_ahead, result_valid_q && danger_q, !time_q[TIME_BITS-1] && time_q != '0 && dist_q != '0, "danger flagged without positive time and distance")
	`CADC_ASSERT_NEXT(a_freeze_on_stall, target_stall, $stable(dist_q) && $stable(time_q), "pipeline moved while stalled")

endmodule

### hw/rtl/cadc_trig.sv
// Four-stage Q15 sine polynomial on a 16-bit phase.
module cadc_trig import cadc_pkg::*; (
	input  logic                        clk,
	input  logic                        en,
	input  logic [15:0]                 phase,
	output logic signed [TRIG_BITS-1:0] sine
);

	logic [14:0] f;
	logic [15:0] x;
	logic [31:0] sq;
	logic [26:0] p2;
	logic [14:0] c3;
	logic [29:0] p3;
	logic [30:0] p4;
	logic [15:0] s16;

	logic [15:0] x_s1, x2_s1, x_s2, x2_s2, x_s3, y_s3;
	logic        neg_s1, neg_s2, neg_s3;
	logic [11:0] t_s2;

	// quarter-wave fold
	always_comb begin
		f = {1'b0, phase[13:0]};
		if (phase[14]) begin
			f = 15'd16384 - f;
		end
		x  = {f, 1'b0};
		sq = 32'(x) * 32'(x);
		p2 = 27'(x2_s1) * 27'd2611;
		c3 = 15'd21167 - 15'(t_s2);
		p3 = 30'(x2_s2) * 30'(c3);
		p4 = 31'(x_s3) * 31'(y_s3);
		s16 = p4[30:15];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= x;
			x2_s1  <= sq[30:15];
			neg_s1 <= phase[15];
			x_s2   <= x_s1;
			x2_s2  <= x2_s1;
			t_s2   <= p2[26:15];
			neg_s2 <= neg_s1;
			x_s3   <= x_s2;
			y_s3   <= 16'd51472 - {1'b0, p3[29:15]};
			neg_s3 <= neg_s2;
			if (s16[15]) begin
				sine <= neg_s3 ? -16'sd32767 : 16'sd32767;
			end else begin
				sine <= neg_s3 ? -signed'(s16) : signed'(s16);
			end
		end
	end

endmodule

### hw/rtl/cadc_geom.sv
// Relative velocity, dot and cross products, and divide operand setup (10 stages).
module cadc_geom import cadc_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_vld,
	input  logic signed [COORD_BITS-1:0] rel_x,
	input  logic signed [COORD_BITS-1:0] rel_y,
	input  logic [COURSE_BITS-1:0]       target_course,
	input  logic [SPEED_BITS-1:0]        target_speed,
	input  logic [COURSE_BITS-1:0]       own_course,
	input  logic [SPEED_BITS-1:0]        own_speed,
	output logic                         out_vld,
	output cadc_op_t                     op
);

	logic [15:0] tp, op_ph;
	logic signed [TRIG_BITS-1:0] sin_t, cos_t, sin_o, cos_o;

	logic                         vld_s [1:10];
	logic signed [COORD_BITS-1:0] dx_s [1:6];
	logic signed [COORD_BITS-1:0] dy_s [1:6];
	logic [SPEED_BITS-1:0]        ts_s [1:4];
	logic [SPEED_BITS-1:0]        os_s [1:4];

	logic signed [PROD33_BITS-1:0] ptx_s5, pox_s5, pty_s5, poy_s5;
	logic signed [VEL_BITS-1:0]    vx_s6, vy_s6;
	logic signed [PROD_BITS-1:0]   xvx_s7, yvy_s7, xvy_s7, yvx_s7;
	logic signed [VSQ_BITS-1:0]    vx2_s7, vy2_s7;
	logic signed [CSQ_BITS-1:0]    x2_s7, y2_s7;
	logic signed [DOT_BITS-1:0]    dot_s8, cr_s8;
	logic [VV_BITS-1:0]            vv_s8, vv_s9;
	logic [CSQ_BITS-1:0]           rr_s8, rr_s9;
	logic [HH_BITS-1:0]            hh_s9;
	logic [HL_BITS-1:0]            hl_s9;
	logic [LL_BITS-1:0]            ll_s9;
	logic [NT_BITS-1:0]            nt_s9;
	logic                          still_s9, tneg_s9;
	cadc_op_t                      op_s10;

	logic [DOT_BITS-1:0] absdot, abscr;
	logic [CRM_BITS-1:0] crm;
	logic [DW-1:0]       cr2;

	assign tp    = phase16(target_course);
	assign op_ph = phase16(own_course);

	cadc_trig u_tsin (.clk(clk), .en(en), .phase(tp),              .sine(sin_t));
	cadc_trig u_tcos (.clk(clk), .en(en), .phase(tp + 16'd16384),    .sine(cos_t));
	cadc_trig u_osin (.clk(clk), .en(en), .phase(op_ph),           .sine(sin_o));
	cadc_trig u_ocos (.clk(clk), .en(en), .phase(op_ph + 16'd16384), .sine(cos_o));

	always_comb begin
		absdot = dot_s8[DOT_BITS-1] ? DOT_BITS'(-dot_s8) : DOT_BITS'(dot_s8);
		abscr  = cr_s8[DOT_BITS-1] ? DOT_BITS'(-cr_s8) : DOT_BITS'(cr_s8);
		crm    = abscr[CRM_BITS-1:0];
		cr2    = (DW'(hh_s9) << (2 * CRM_LO)) + (DW'(hl_s9) << (CRM_LO + 1)) + DW'(ll_s9);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= 10; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s[1] <= in_vld;
			for (int i = 2; i <= 10; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s[1] <= rel_x;
			dy_s[1] <= rel_y;
			ts_s[1] <= target_speed;
			os_s[1] <= own_speed;
			for (int i = 2; i <= 6; i++) begin
				dx_s[i] <= dx_s[i-1];
				dy_s[i] <= dy_s[i-1];
			end
			for (int i = 2; i <= 4; i++) begin
				ts_s[i] <= ts_s[i-1];
				os_s[i] <= os_s[i-1];
			end
			// speed times trig, Q15
			ptx_s5 <= PROD33_BITS'(signed'({1'b0, ts_s[4]})) * PROD33_BITS'(sin_t);
			pox_s5 <= PROD33_BITS'(signed'({1'b0, os_s[4]})) * PROD33_BITS'(sin_o);
			pty_s5 <= PROD33_BITS'(signed'({1'b0, ts_s[4]})) * PROD33_BITS'(cos_t);
			poy_s5 <= PROD33_BITS'(signed'({1'b0, os_s[4]})) * PROD33_BITS'(cos_o);
			// floor by 2^15
			vx_s6 <= VEL_BITS'((ptx_s5 - pox_s5) >>> 15);
			vy_s6 <= VEL_BITS'((pty_s5 - poy_s5) >>> 15);
			xvx_s7 <= PROD_BITS'(dx_s[6]) * PROD_BITS'(vx_s6);
			yvy_s7 <= PROD_BITS'(dy_s[6]) * PROD_BITS'(vy_s6);
			xvy_s7 <= PROD_BITS'(dx_s[6]) * PROD_BITS'(vy_s6);
			yvx_s7 <= PROD_BITS'(dy_s[6]) * PROD_BITS'(vx_s6);
			vx2_s7 <= VSQ_BITS'(vx_s6) * VSQ_BITS'(vx_s6);
			vy2_s7 <= VSQ_BITS'(vy_s6) * VSQ_BITS'(vy_s6);
			x2_s7  <= CSQ_BITS'(dx_s[6]) * CSQ_BITS'(dx_s[6]);
			y2_s7  <= CSQ_BITS'(dy_s[6]) * CSQ_BITS'(dy_s[6]);
			dot_s8 <= DOT_BITS'(xvx_s7) + DOT_BITS'(yvy_s7);
			cr_s8  <= DOT_BITS'(xvy_s7) - DOT_BITS'(yvx_s7);
			vv_s8  <= $unsigned(vx2_s7) + $unsigned(vy2_s7);
			rr_s8  <= $unsigned(x2_s7) + $unsigned(y2_s7);
			// cross product squared as three partial products
			hh_s9 <= HH_BITS'(crm[CRM_BITS-1:CRM_LO]) * HH_BITS'(crm[CRM_BITS-1:CRM_LO]);
			hl_s9 <= HL_BITS'(crm[CRM_BITS-1:CRM_LO]) * HL_BITS'(crm[CRM_LO-1:0]);
			ll_s9 <= LL_BITS'(crm[CRM_LO-1:0]) * LL_BITS'(crm[CRM_LO-1:0]);
			nt_s9    <= {absdot, TIME_SHIFT'(0)};
			still_s9 <= (vv_s8 == '0);
			tneg_s9  <= !dot_s8[DOT_BITS-1] && (dot_s8 != '0);
			vv_s9    <= vv_s8;
			rr_s9    <= rr_s8;
			// no relative motion: range is root of r.r over a unit divisor
			op_s10.still <= still_s9;
			op_s10.tneg  <= tneg_s9;
			op_s10.nt    <= nt_s9;
			op_s10.dv    <= still_s9 ? VV_BITS'(1) : vv_s9;
			op_s10.dd    <= still_s9 ? DW'(rr_s9) : cr2;
		end
	end

	assign out_vld = vld_s[10];
	assign op      = op_s10;

endmodule

### hw/rtl/cadc_div.sv
// Bit-per-stage restoring dividers for time and squared miss distance.
module cadc_div import cadc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      in_vld,
	input  cadc_op_t  op,
	output logic      out_vld,
	output cadc_quo_t quo
);

	logic               vld_s  [0:DQ_BITS];
	logic [TW-1:0]      trem_s [0:DQ_BITS];
	logic [TQ_BITS-1:0] tq_s   [0:DQ_BITS];
	logic [DW-1:0]      drem_s [0:DQ_BITS];
	logic [DQ_BITS-1:0] dq_s   [0:DQ_BITS];
	logic [VV_BITS-1:0] dv_s   [0:DQ_BITS];
	cadc_side_t         sb_s   [0:DQ_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= DQ_BITS; j++) begin
				vld_s[j] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= in_vld;
			for (int j = 1; j <= DQ_BITS; j++) begin
				vld_s[j] <= vld_s[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// range check first so the quotients fit their bit counts
			sb_s[0].still <= op.still;
			sb_s[0].tneg  <= op.tneg;
			sb_s[0].tovf  <= TW'(op.nt) >= (TW'(op.dv) << TQ_BITS);
			sb_s[0].dovf  <= op.dd >= (DW'(op.dv) << DQ_BITS);
			sb_s[0].tq    <= '0;
			trem_s[0] <= TW'(op.nt);
			tq_s[0]   <= '0;
			drem_s[0] <= op.dd;
			dq_s[0]   <= '0;
			dv_s[0]   <= op.dv;
			for (int j = 1; j <= DQ_BITS; j++) begin
				dv_s[j] <= dv_s[j-1];
				sb_s[j] <= sb_s[j-1];
				if (drem_s[j-1] >= (DW'(dv_s[j-1]) << (DQ_BITS - j))) begin
					drem_s[j] <= drem_s[j-1] - (DW'(dv_s[j-1]) << (DQ_BITS - j));
					dq_s[j]   <= dq_s[j-1] | (DQ_BITS'(1) << (DQ_BITS - j));
				end else begin
					drem_s[j] <= drem_s[j-1];
					dq_s[j]   <= dq_s[j-1];
				end
				if (j <= TQ_BITS &&
				    trem_s[j-1] >= (TW'(dv_s[j-1]) << (TQ_BITS - j))) begin
					trem_s[j] <= trem_s[j-1] - (TW'(dv_s[j-1]) << (TQ_BITS - j));
					tq_s[j]   <= tq_s[j-1] | (TQ_BITS'(1) << (TQ_BITS - j));
				end else begin
					trem_s[j] <= trem_s[j-1];
					tq_s[j]   <= tq_s[j-1];
				end
			end
		end
	end

	always_comb begin
		quo.side    = sb_s[DQ_BITS];
		quo.side.tq = tq_s[DQ_BITS];
		quo.dq      = dq_s[DQ_BITS];
	end

	assign out_vld = vld_s[DQ_BITS];

endmodule

### hw/rtl/cadc_sqrt.sv
// Digit-per-stage integer square root of the squared miss distance.
module cadc_sqrt import cadc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  cadc_quo_t            quo,
	output logic                 out_vld,
	output cadc_side_t           side,
	output logic [DIST_BITS-1:0] root
);

	logic       vld_s [1:DIST_BITS];
	cadc_root_t rt_s  [1:DIST_BITS];
	cadc_side_t sb_s  [1:DIST_BITS];
	cadc_root_t rt_in;

	assign rt_in = '{rem: SQ_W'(quo.dq), root: '0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 1; j <= DIST_BITS; j++) begin
				vld_s[j] <= 1'b0;
			end
		end else if (en) begin
			vld_s[1] <= in_vld;
			for (int j = 2; j <= DIST_BITS; j++) begin
				vld_s[j] <= vld_s[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rt_s[1] <= root_step(rt_in, DIST_BITS - 1);
			sb_s[1] <= quo.side;
			for (int j = 2; j <= DIST_BITS; j++) begin
				rt_s[j] <= root_step(rt_s[j-1], DIST_BITS - j);
				sb_s[j] <= sb_s[j-1];
			end
		end
	end

	assign out_vld = vld_s[DIST_BITS];
	assign side    = sb_s[DIST_BITS];
	assign root    = rt_s[DIST_BITS].root;

endmodule

### tb/tb.sv
// Self-checking testbench for closest_approach_danger_check_core with a bit-exact CPA predictor.
`timescale 1ns / 100ps

module tb;
	import cadc_pkg::*;

	localparam int  LAT_CYCLES  = 84;
	localparam longint CYCLE_LIMIT = 400000;
	localparam longint unsigned DIST_SAT = 64'd16777215;

	typedef struct {
		logic signed [TIME_BITS-1:0] tcpa;
		logic [DIST_BITS-1:0]        dcpa;
		logic                        danger;
		logic                        still;
	} cpa_result_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [CFG_IDX_BITS-1:0]      cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]     cfg_data = '0;
	logic                         target_valid = 1'b0;
	logic                         target_stall;
	logic signed [COORD_BITS-1:0] rel_x = '0;
	logic signed [COORD_BITS-1:0] rel_y = '0;
	logic [COURSE_BITS-1:0]       target_course = '0;
	logic [SPEED_BITS-1:0]        target_speed = '0;
	logic                         result_valid;
	logic                         result_stall = 1'b0;
	logic signed [TIME_BITS-1:0]  time_to_closest;
	logic [DIST_BITS-1:0]         closest_distance;
	logic                         is_danger;
	logic                         no_relative_motion;

	// shadow of the configuration registers
	logic [15:0] own_course_r, own_speed_r;
	logic [23:0] danger_dist_r;
	logic [30:0] danger_time_r;

	cpa_result_t pending_cpa_q[$];
	int          error_count = 0;
	longint      cycle_count = 0;
	int          stall_pct = 0;
	int          hold_req = 0;
	int          hold_left = 0;
	int          burst_left = 0;
	int          gap_max = 0;

	closest_approach_danger_check_core DUT (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic longint trig_q15(input logic [15:0] p);
		longint unsigned f, x, x2, t, y, s;
		f = 64'(p[13:0]);
		if (p[14]) f = 16384 - f;
		x  = f << 1;
		x2 = (x * x) >> 15;
		t  = (x2 * 2611) >> 15;
		y  = 51472 - ((x2 * (21167 - t)) >> 15);
		s  = (x * y) >> 15;
		if (s > 32767) s = 32767;
		return p[15] ? -longint'(s) : longint'(s);
	endfunction

	// largest d up to the saturation value with d*d*w <= n
	function automatic logic [23:0] fit_root(input logic [127:0] w, input logic [127:0] n);
		longint unsigned lo, hi, mid;
		logic [127:0] prod;
		lo = 0;
		hi = DIST_SAT;
		while (lo < hi) begin
			mid  = (lo + hi + 1) >> 1;
			prod = 128'(mid) * 128'(mid) * w;
			if (prod <= n) lo = mid;
			else hi = mid - 1;
		end
		return lo[23:0];
	endfunction

	function automatic cpa_result_t predict_cpa(input logic signed [23:0] x,
			input logic signed [23:0] y, input logic [15:0] crs, input logic [15:0] spd);
		cpa_result_t r;
		longint dx, dy, ts, os, dvx, dvy, vv, dot, cr, t;
		logic [127:0] ac;
		dx  = longint'(x);
		dy  = longint'(y);
		ts  = longint'(spd);
		os  = longint'(own_speed_r);
		dvx = (ts * trig_q15(crs) - os * trig_q15(own_course_r)) >>> 15;
		dvy = (ts * trig_q15(crs + 16'd16384) - os * trig_q15(own_course_r + 16'd16384)) >>> 15;
		vv  = dvx * dvx + dvy * dvy;
		t   = 0;
		r.still = (vv == 0);
		if (r.still) begin
			r.dcpa = fit_root(128'd1, 128'(dx * dx + dy * dy));
		end else begin
			dot = dx * dvx + dy * dvy;
			cr  = dx * dvy - dy * dvx;
			ac  = 128'(cr < 0 ? -cr : cr);
			t   = (-dot * 4096) / vv;
			if (t > 64'sd2147483647) t = 64'sd2147483647;
			if (t < -64'sd2147483648) t = -64'sd2147483648;
			r.dcpa = fit_root(128'(vv), ac * ac);
		end
		r.tcpa   = t[31:0];
		r.danger = t > 0 && t < longint'(danger_time_r) && r.dcpa != 0
			&& r.dcpa < danger_dist_r;
		return r;
	endfunction

	task automatic report_mismatch(input string field, input longint got, input longint want);
		$display("MISMATCH %s: got %0d expected %0d (cycle %0d)", field, got, want, cycle_count);
		error_count++;
	endtask

	// result checker
	always @(posedge clk) begin
		cpa_result_t e;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_cpa_q.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				e = pending_cpa_q.pop_front();
				if (time_to_closest !== e.tcpa)
					report_mismatch("time_to_closest", time_to_closest, e.tcpa);
				if (closest_distance !== e.dcpa)
					report_mismatch("closest_distance", closest_distance, e.dcpa);
				if (is_danger !== e.danger)
					report_mismatch("is_danger", is_danger, e.danger);
				if (no_relative_motion !== e.still)
					report_mismatch("no_relative_motion", no_relative_motion, e.still);
			end
		end
	end

	// receiver: random stall pattern, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("closest_approach_danger_check_core verification failed");
			$finish;
		end
	end

	task automatic send_target(input logic [23:0] x, input logic [23:0] y,
			input logic [15:0] crs, input logic [15:0] spd);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if (gap_max > 0) begin
				gap = $urandom_range(0, gap_max);
				if (gap > 0) begin
					target_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
		burst_left--;
		target_valid  <= 1'b1;
		rel_x         <= x;
		rel_y         <= y;
		target_course <= crs;
		target_speed  <= spd;
		@(posedge clk);
		while (target_stall) @(posedge clk);
		pending_cpa_q.push_back(predict_cpa(x, y, crs, spd));
	endtask

	task automatic drain;
		target_valid <= 1'b0;
		while (pending_cpa_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_cfg(input cfg_reg_t idx, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_OWN_COURSE:      own_course_r  = value[15:0];
			CFG_OWN_SPEED:       own_speed_r   = value[15:0];
			CFG_DANGER_DISTANCE: danger_dist_r = value[23:0];
			CFG_DANGER_TIME:     danger_time_r = value[30:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [15:0] crs, input logic [15:0] spd,
			input logic [23:0] dd, input logic [30:0] dt);
		drain();
		// junk in the unused upper bits must be ignored
		write_cfg(CFG_OWN_COURSE, {16'($urandom), crs});
		write_cfg(CFG_OWN_SPEED, {16'($urandom), spd});
		write_cfg(CFG_DANGER_DISTANCE, {8'($urandom), dd});
		write_cfg(CFG_DANGER_TIME, {1'($urandom), dt});
	endtask

	task automatic send_random(input int n);
		logic [23:0] x, y;
		repeat (n) begin
			if ($urandom_range(3) == 0) begin
				x = 24'($urandom);
				y = 24'($urandom);
			end else begin
				x = 24'($signed(13'($urandom)));
				y = 24'($signed(13'($urandom)));
			end
			case ($urandom_range(5))
				0: send_target(x, y, own_course_r, own_speed_r);
				1: send_target(x, y, 16'($urandom), 16'($urandom_range(0, 3)));
				default: send_target(x, y, 16'($urandom), 16'($urandom));
			endcase
		end
	endtask

	task automatic test_directed;
		stall_pct = 0;
		gap_max   = 0;
		// reset config: own ship still, zero target speed is no relative motion
		send_target(24'h000000, 24'h000000, 16'h0000, 16'h0000);
		send_target(24'h7FFFFF, 24'h7FFFFF, 16'h0000, 16'h0000);
		send_target(24'h800000, 24'h800000, 16'h4000, 16'h0000);
		send_target(24'h000003, 24'h000004, 16'hFFFF, 16'h0000);
		set_config(16'h0000, 16'h0100, 24'hFFFFFF, 31'h7FFFFFFF);
		// identical course and speed: zero relative velocity with moving ships
		send_target(24'h000100, 24'h000200, 16'h0000, 16'h0100);
		// heading toward, heading away (already past), crossing
		send_target(24'h000000, 24'h001000, 16'h8000, 16'h0100);
		send_target(24'h000000, 24'hFFF000, 16'h8000, 16'h0100);
		send_target(24'h001000, 24'h001000, 16'hC000, 16'h0200);
		send_target(24'h7FFFFF, 24'h800000, 16'h4000, 16'hFFFF);
		send_target(24'h800000, 24'h7FFFFF, 16'hC000, 16'hFFFF);
		send_target(24'h000000, 24'h000000, 16'h2000, 16'hFFFF);
		send_target(24'h000001, 24'hFFFFFF, 16'h6000, 16'h0001);
		set_config(16'hFFFF, 16'hFFFF, 24'h000000, 31'h0);
		send_target(24'h7FFFFF, 24'h7FFFFF, 16'h0000, 16'hFFFF);
		send_target(24'h800000, 24'h800000, 16'h7FFF, 16'hFFFF);
		send_target(24'h000010, 24'h000010, 16'hFFFF, 16'hFFFF);
		send_target(24'hFFFFF0, 24'h000010, 16'hA000, 16'h0000);
		set_config(16'h8000, 16'h8000, 24'h000400, 31'h00010000);
		send_target(24'h000000, 24'h000200, 16'h0000, 16'h8000);
		send_target(24'h000100, 24'hFFFF00, 16'h1234, 16'h4000);
	endtask

	task automatic test_random_settings;
		int k;
		for (k = 0; k < 4; k++) begin
			stall_pct = (k == 0) ? 0 : $urandom_range(10, 70);
			gap_max   = (k == 1) ? 0 : $urandom_range(1, 12);
			set_config(16'($urandom), (k == 2) ? 16'h0 : 16'($urandom),
				(k == 3) ? 24'hFFFFFF : 24'($urandom_range(16, 20000)),
				(k == 3) ? 31'h7FFFFFFF : 31'($urandom_range(1, 1 << 24)));
			send_random(90);
		end
	endtask

	// more items than the pipeline holds, so the input stalls during the hold-off
	task automatic test_backpressure;
		stall_pct = 20;
		gap_max   = 0;
		set_config(16'($urandom), 16'($urandom_range(0, 4096)), 24'h010000, 31'h00100000);
		burst_left = 0;
		hold_req   = 300;
		send_random(120);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		own_course_r  = '0;
		own_speed_r   = '0;
		danger_dist_r = '0;
		danger_time_r = '0;
		@(posedge clk);
		test_directed();
		test_random_settings();
		test_backpressure();
		drain();
		repeat (LAT_CYCLES + 16) @(posedge clk);
		if (error_count == 0 && pending_cpa_q.size() == 0) begin
			$display("closest_approach_danger_check_core verification clean");
		end else begin
			$display("closest_approach_danger_check_core verification failed");
		end
		$finish;
	end

endmodule

### closest_approach_danger_check_core.f
+incdir+hw/rtl
hw/rtl/cadc_pkg.sv
hw/rtl/cadc_trig.sv
hw/rtl/cadc_geom.sv
hw/rtl/cadc_div.sv
hw/rtl/cadc_sqrt.sv
hw/rtl/closest_approach_danger_check_core.sv
tb/tb.sv
